// File: rtl/tsz_pkg.sv
// shared constants, types and codes for the zero-sum triplet finder
package tsz_pkg;

    localparam int VALUE_WIDTH  = 16;
    localparam int MAX_ELEMENTS = 16;
    localparam int MAX_TRIPLETS = 64;

    // derived widths
    localparam int IDX_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int TRI_W   = $clog2(MAX_TRIPLETS + 1);
    localparam int TADDR_W = (MAX_TRIPLETS > 1) ? $clog2(MAX_TRIPLETS) : 1;
    localparam int SUM_W   = VALUE_WIDTH + 2;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic [TRI_W-1:0]              tri_cnt_t;
    typedef logic [TADDR_W-1:0]            tri_addr_t;

    typedef struct packed {
        value_t first;
        value_t second;
        value_t third;
    } triplet_t;

    // shared adder operation
    typedef enum logic {
        ALU_SUB  = 1'b0,
        ALU_ADD3 = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } alu_flag_t;

    // write side of the result buffer
    typedef struct packed {
        logic      en;
        tri_addr_t addr;
        triplet_t  data;
    } rbuf_wr_t;

    // request to send the buffered results
    typedef struct packed {
        logic     start;
        tri_cnt_t count;
        logic     found;
        logic     trunc;
    } drain_cmd_t;

endpackage

// File: rtl/tsz_in_if.sv
// input channel: one element per beat
interface tsz_in_if;
    import tsz_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// File: rtl/tsz_res_if.sv
// result channel: one triplet per beat
interface tsz_res_if;
    import tsz_pkg::*;

    logic   valid;
    logic   ready;
    value_t first;
    value_t second;
    value_t third;
    logic   found;
    logic   done_res;
    logic   truncated;

    modport source (output valid, output first, output second, output third,
                    output found, output done_res, output truncated, input ready);
    modport sink   (input valid, input first, input second, input third,
                    input found, input done_res, input truncated, output ready);
endinterface

// File: rtl/tsz_alu.sv
// shared adder: three-operand sum or two-operand difference, with sign and zero flags
module tsz_alu (
    input  tsz_pkg::alu_op_t   op,
    input  tsz_pkg::value_t    a,
    input  tsz_pkg::value_t    b,
    input  tsz_pkg::value_t    c,
    output tsz_pkg::alu_flag_t flag
);
    import tsz_pkg::*;

    sum_t ext_a;
    sum_t ext_b;
    sum_t ext_c;
    sum_t sum;

    // sign extend so the sum never wraps
    assign ext_a = SUM_W'(a);
    assign ext_b = SUM_W'(b);
    assign ext_c = SUM_W'(c);

    always_comb
    begin
        unique case (op)
            ALU_ADD3: sum = ext_a + ext_b + ext_c;
            ALU_SUB:  sum = ext_a - ext_b;
            default:  sum = ext_a - ext_b;
        endcase
    end

    assign flag.neg  = sum[SUM_W-1];
    assign flag.zero = (sum == '0);

endmodule

// File: rtl/tsz_rbuf.sv
// result buffer: holds the triplets of one run and sends them out in order
module tsz_rbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  tsz_pkg::rbuf_wr_t   wr,
    input  tsz_pkg::drain_cmd_t cmd,
    output logic                drain_done,
    tsz_res_if.source           results
);
    import tsz_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE,
        D_RD,
        D_SHOW
    } dstate_t;

    dstate_t  state_reg, state_next;
    tri_cnt_t k_reg, k_next;
    tri_cnt_t cnt_reg, cnt_next;
    logic     found_reg, found_next;
    logic     trunc_reg, trunc_next;

    triplet_t res_mem [MAX_TRIPLETS];
    triplet_t rdata_reg;
    logic     rd_en;
    logic     last_beat;
    logic     beat;

    // triplet store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            res_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= res_mem[k_reg[TADDR_W-1:0]];
        end
    end

    assign rd_en      = (state_reg == D_RD);
    assign last_beat  = (k_reg == TRI_W'(cnt_reg - 1'b1));
    assign beat       = (state_reg == D_SHOW) && results.ready;
    assign drain_done = beat && last_beat;

    // result beat
    assign results.valid     = (state_reg == D_SHOW);
    assign results.first     = found_reg ? rdata_reg.first  : '0;
    assign results.second    = found_reg ? rdata_reg.second : '0;
    assign results.third     = found_reg ? rdata_reg.third  : '0;
    assign results.found     = found_reg;
    assign results.done_res  = last_beat;
    assign results.truncated = trunc_reg;

    // drain sequencer
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        trunc_next = trunc_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (cmd.start)
                begin
                    k_next     = '0;
                    cnt_next   = cmd.count;
                    found_next = cmd.found;
                    trunc_next = cmd.trunc;
                    state_next = D_RD;
                end
            end
            D_RD:
            begin
                state_next = D_SHOW;
            end
            D_SHOW:
            begin
                if (beat)
                begin
                    if (last_beat)
                    begin
                        state_next = D_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = D_RD;
                    end
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            trunc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            trunc_reg <= trunc_next;
        end
    end

endmodule

// File: rtl/three_sum_zero_triplets_top.sv
// Zero-sum triplet finder: loads a set, sorts it, searches it with two pointers.
// Loading stores each element while there is room; the beat marked last starts the run.
// Sort: bubble passes through the element store's single read port.
// Search: outer steps, pointer moves and duplicate skips all run on one adder.
// Results then leave one beat at a time, each read from the buffer before it is shown; inputs wait until the last one.
// Reset (asynchronous, active low) empties the store and returns to loading; no clearing pass.
module three_sum_zero_triplets_top (
    input  logic      clk,
    input  logic      rst_n,
    tsz_in_if.sink    items,
    tsz_res_if.source results
);
    import tsz_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD,
        S_SORT_INIT,
        S_P_RD0,
        S_P_GET0,
        S_P_RD,
        S_P_CMP,
        S_P_END,
        S_SRCH_INIT,
        S_OUT_RD,
        S_OUT_CHK,
        S_HI_RD,
        S_HI_GET,
        S_LO_RD,
        S_LO_GET,
        S_SUM,
        S_SKL_RD,
        S_SKL_CHK,
        S_SKH_RD,
        S_SKH_CHK,
        S_FINISH,
        S_DRAIN
    } state_t;

    state_t   state_reg, state_next;
    cnt_t     count_reg, count_next;
    logic     ovf_reg, ovf_next;
    idx_t     m_reg, m_next;
    idx_t     j_reg, j_next;
    value_t   carry_reg, carry_next;
    idx_t     i_reg, i_next;
    idx_t     lo_reg, lo_next;
    idx_t     hi_reg, hi_next;
    value_t   val_i_reg, val_i_next;
    value_t   val_lo_reg, val_lo_next;
    value_t   val_hi_reg, val_hi_next;
    logic     need_lo_reg, need_lo_next;
    tri_cnt_t emit_reg, emit_next;

    // element store
    value_t elem_mem [MAX_ELEMENTS];
    value_t mem_rdata_reg;
    logic   mem_we;
    idx_t   mem_waddr;
    value_t mem_wdata;
    logic   mem_re;
    idx_t   mem_raddr;

    // shared adder
    alu_op_t   alu_op;
    value_t    alu_a;
    value_t    alu_b;
    value_t    alu_c;
    alu_flag_t alu_flag;

    rbuf_wr_t   rb_wr;
    drain_cmd_t drain_cmd;
    logic       drain_done;

    idx_t lo_inc;
    idx_t hi_dec;
    idx_t last_idx;
    logic outer_more;
    logic store_room;
    logic cap_hit;

    assign lo_inc     = lo_reg + 1'b1;
    assign hi_dec     = hi_reg - 1'b1;
    assign last_idx   = IDX_W'(count_reg - 1'b1);
    assign outer_more = ((CNT_W+1)'(i_reg) + (CNT_W+1)'(3)) < (CNT_W+1)'(count_reg);
    assign store_room = (count_reg < CNT_W'(MAX_ELEMENTS));
    assign cap_hit    = (emit_reg == TRI_W'(MAX_TRIPLETS));

    assign items.ready = (state_reg == S_LOAD);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            elem_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= elem_mem[mem_raddr];
        end
    end

    tsz_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .c    (alu_c),
        .flag (alu_flag)
    );

    tsz_rbuf u_rbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (rb_wr),
        .cmd        (drain_cmd),
        .drain_done (drain_done),
        .results    (results)
    );

    // drain request once the search has ended
    assign drain_cmd.start = (state_reg == S_FINISH);
    assign drain_cmd.count = (emit_reg == '0) ? TRI_W'(1) : emit_reg;
    assign drain_cmd.found = (emit_reg != '0);
    assign drain_cmd.trunc = ovf_reg;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        m_next       = m_reg;
        j_next       = j_reg;
        carry_next   = carry_reg;
        i_next       = i_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        val_i_next   = val_i_reg;
        val_lo_next  = val_lo_reg;
        val_hi_next  = val_hi_reg;
        need_lo_next = need_lo_reg;
        emit_next    = emit_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = carry_reg;
        mem_re    = 1'b0;
        mem_raddr = '0;

        alu_op = ALU_SUB;
        alu_a  = mem_rdata_reg;
        alu_b  = carry_reg;
        alu_c  = '0;

        rb_wr.en   = 1'b0;
        rb_wr.addr = emit_reg[TADDR_W-1:0];
        rb_wr.data = '{first: val_i_reg, second: val_lo_reg, third: val_hi_reg};

        unique case (state_reg)
            // store elements until the last beat
            S_LOAD:
            begin
                if (items.valid)
                begin
                    if (store_room)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IDX_W-1:0];
                        mem_wdata  = items.value;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (items.last)
                    begin
                        state_next = S_SORT_INIT;
                    end
                end
            end
            // bubble sort, carrying the running maximum through each pass
            S_SORT_INIT:
            begin
                if (count_reg >= CNT_W'(2))
                begin
                    m_next     = last_idx;
                    state_next = S_P_RD0;
                end
                else
                begin
                    state_next = S_SRCH_INIT;
                end
            end
            S_P_RD0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                j_next     = IDX_W'(1);
                state_next = S_P_GET0;
            end
            S_P_GET0:
            begin
                carry_next = mem_rdata_reg;
                state_next = S_P_RD;
            end
            S_P_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = j_reg;
                state_next = S_P_CMP;
            end
            S_P_CMP:
            begin
                alu_a     = carry_reg;
                alu_b     = mem_rdata_reg;
                mem_we    = 1'b1;
                mem_waddr = j_reg - 1'b1;
                if (!alu_flag.neg && !alu_flag.zero)
                begin
                    mem_wdata = mem_rdata_reg;
                end
                else
                begin
                    mem_wdata  = carry_reg;
                    carry_next = mem_rdata_reg;
                end
                if (j_reg == m_reg)
                begin
                    state_next = S_P_END;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_P_RD;
                end
            end
            S_P_END:
            begin
                mem_we    = 1'b1;
                mem_waddr = m_reg;
                mem_wdata = carry_reg;
                if (m_reg == IDX_W'(1))
                begin
                    state_next = S_SRCH_INIT;
                end
                else
                begin
                    m_next     = m_reg - 1'b1;
                    state_next = S_P_RD0;
                end
            end
            // two-pointer search
            S_SRCH_INIT:
            begin
                i_next    = '0;
                emit_next = '0;
                if (count_reg >= CNT_W'(3))
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_OUT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = i_reg;
                state_next = S_OUT_CHK;
            end
            S_OUT_CHK:
            begin
                // skip an outer value equal to the one before it
                alu_a      = mem_rdata_reg;
                alu_b      = val_i_reg;
                val_i_next = mem_rdata_reg;
                if ((i_reg != '0) && alu_flag.zero)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = outer_more ? S_OUT_RD : S_FINISH;
                end
                else
                begin
                    lo_next      = i_reg + 1'b1;
                    hi_next      = last_idx;
                    need_lo_next = 1'b1;
                    state_next   = S_HI_RD;
                end
            end
            S_HI_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = hi_reg;
                state_next = S_HI_GET;
            end
            S_HI_GET:
            begin
                val_hi_next = mem_rdata_reg;
                state_next  = need_lo_reg ? S_LO_RD : S_SUM;
            end
            S_LO_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = lo_reg;
                state_next = S_LO_GET;
            end
            S_LO_GET:
            begin
                val_lo_next  = mem_rdata_reg;
                need_lo_next = 1'b0;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                alu_op = ALU_ADD3;
                alu_a  = val_i_reg;
                alu_b  = val_lo_reg;
                alu_c  = val_hi_reg;
                if (alu_flag.neg)
                begin
                    lo_next = lo_inc;
                    if (lo_inc < hi_reg)
                    begin
                        state_next = S_LO_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = outer_more ? S_OUT_RD : S_FINISH;
                    end
                end
                else if (!alu_flag.zero)
                begin
                    hi_next = hi_dec;
                    if (lo_reg < hi_dec)
                    begin
                        state_next = S_HI_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = outer_more ? S_OUT_RD : S_FINISH;
                    end
                end
                else if (cap_hit)
                begin
                    ovf_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    rb_wr.en  = 1'b1;
                    emit_next = emit_reg + 1'b1;
                    lo_next   = lo_inc;
                    hi_next   = hi_dec;
                    if (lo_inc < hi_dec)
                    begin
                        state_next = S_SKL_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = outer_more ? S_OUT_RD : S_FINISH;
                    end
                end
            end
            // step the low pointer over duplicates
            S_SKL_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = lo_reg;
                state_next = S_SKL_CHK;
            end
            S_SKL_CHK:
            begin
                alu_a       = mem_rdata_reg;
                alu_b       = val_lo_reg;
                val_lo_next = mem_rdata_reg;
                if (alu_flag.zero)
                begin
                    lo_next = lo_inc;
                    if (lo_inc < hi_reg)
                    begin
                        state_next = S_SKL_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = outer_more ? S_OUT_RD : S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_SKH_RD;
                end
            end
            // step the high pointer over duplicates
            S_SKH_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = hi_reg;
                state_next = S_SKH_CHK;
            end
            S_SKH_CHK:
            begin
                alu_a       = mem_rdata_reg;
                alu_b       = val_hi_reg;
                val_hi_next = mem_rdata_reg;
                if (alu_flag.zero)
                begin
                    hi_next = hi_dec;
                    if (lo_reg < hi_dec)
                    begin
                        state_next = S_SKH_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = outer_more ? S_OUT_RD : S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            // hand the run over to the result buffer
            S_FINISH:
            begin
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (drain_done)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    emit_next  = '0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_reg       <= '0;
            j_reg       <= '0;
            carry_reg   <= '0;
            i_reg       <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            val_i_reg   <= '0;
            val_lo_reg  <= '0;
            val_hi_reg  <= '0;
            need_lo_reg <= 1'b0;
            emit_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_reg       <= m_next;
            j_reg       <= j_next;
            carry_reg   <= carry_next;
            i_reg       <= i_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            val_i_reg   <= val_i_next;
            val_lo_reg  <= val_lo_next;
            val_hi_reg  <= val_hi_next;
            need_lo_reg <= need_lo_next;
            emit_reg    <= emit_next;
        end
    end

endmodule

// File: rtl/tsz_checker.sv
// port-level checks for the triplet finder, bound to the top level
module tsz_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            in_last,
    input logic            res_valid,
    input logic            res_ready,
    input tsz_pkg::value_t first,
    input tsz_pkg::value_t second,
    input tsz_pkg::value_t third,
    input logic            found,
    input logic            done_res,
    input logic            truncated
);
    import tsz_pkg::*;

    // loading and sending never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && res_valid))
        else $error("input taken while a result is shown");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(first) && $stable(second)
            && $stable(third) && $stable(found) && $stable(done_res) && $stable(truncated))
        else $error("stalled result changed");

    // the empty result is alone and all zero
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !found |-> done_res && (first == '0) && (second == '0) && (third == '0))
        else $error("bad empty result");

    // the last element closes the input
    a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input still open after last element");

    // the final result reopens the input
    a_done_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && done_res |=> in_ready)
        else $error("input not reopened after the run");

endmodule

bind three_sum_zero_triplets_top tsz_checker u_tsz_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_last   (items.last),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .first     (results.first),
    .second    (results.second),
    .third     (results.third),
    .found     (results.found),
    .done_res  (results.done_res),
    .truncated (results.truncated)
);
